// ===== sv/tcpt_pkg.sv =====
// tcpt_pkg: shared types, codes and the multiply/accumulate step table
// for the tetrahedron critical point test. No dependencies.
`timescale 1ns / 1ps

package tcpt_pkg;

  localparam int SLOT_BITS = 2;
  localparam int DET_BITS  = 3;
  localparam int STEP_BITS = 4;
  localparam int NUM_DETS  = 5;

  localparam logic [DET_BITS-1:0]  DET_POS   = 3'd4;
  localparam logic [STEP_BITS-1:0] STEP_LAST = 4'd15;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = 2'd3;

  localparam logic [1:0] IDX_NONE = 2'b00;
  localparam logic [1:0] IDX_POS  = 2'b01;
  localparam logic [1:0] IDX_NEG  = 2'b11;

  typedef enum logic [2:0] {
    A_U0, A_U1, A_U2, A_V0, A_V1, A_V2
  } a_sel_t;

  typedef enum logic [2:0] {
    B_W0, B_W1, B_W2, B_TLO, B_THI
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_T_LOAD, ACC_T_SUB, ACC_DET_LOAD, ACC_DET_ADD, ACC_DET_ADD_HI
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc;
  } step_ctl_t;

  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] slot;
    logic                 load;
    logic                 step_vld;
    logic [STEP_BITS-1:0] step;
    logic                 sign_cap;
    logic                 finish;
    logic [DET_BITS-1:0]  det_idx;
  } dp_cmd_t;

  // acc acts on the product issued in the previous step
  function automatic step_ctl_t step_ctl(input logic [STEP_BITS-1:0] s);
    step_ctl_t c;
    c = '{a_sel: A_U0, b_sel: B_W0, acc: ACC_NONE};
    case (s)
      4'd0:  c = '{a_sel: A_V1, b_sel: B_W2,  acc: ACC_NONE};
      4'd1:  c = '{a_sel: A_V2, b_sel: B_W1,  acc: ACC_T_LOAD};
      4'd2:  c = '{a_sel: A_U0, b_sel: B_W0,  acc: ACC_T_SUB};
      4'd3:  c = '{a_sel: A_U0, b_sel: B_TLO, acc: ACC_NONE};
      4'd4:  c = '{a_sel: A_U0, b_sel: B_THI, acc: ACC_DET_LOAD};
      4'd5:  c = '{a_sel: A_V2, b_sel: B_W0,  acc: ACC_DET_ADD_HI};
      4'd6:  c = '{a_sel: A_V0, b_sel: B_W2,  acc: ACC_T_LOAD};
      4'd7:  c = '{a_sel: A_U0, b_sel: B_W0,  acc: ACC_T_SUB};
      4'd8:  c = '{a_sel: A_U1, b_sel: B_TLO, acc: ACC_NONE};
      4'd9:  c = '{a_sel: A_U1, b_sel: B_THI, acc: ACC_DET_ADD};
      4'd10: c = '{a_sel: A_V0, b_sel: B_W1,  acc: ACC_DET_ADD_HI};
      4'd11: c = '{a_sel: A_V1, b_sel: B_W0,  acc: ACC_T_LOAD};
      4'd12: c = '{a_sel: A_U0, b_sel: B_W0,  acc: ACC_T_SUB};
      4'd13: c = '{a_sel: A_U2, b_sel: B_TLO, acc: ACC_NONE};
      4'd14: c = '{a_sel: A_U2, b_sel: B_THI, acc: ACC_DET_ADD};
      4'd15: c = '{a_sel: A_U0, b_sel: B_W0,  acc: ACC_DET_ADD_HI};
      default: c = '{a_sel: A_U0, b_sel: B_W0, acc: ACC_NONE};
    endcase
    return c;
  endfunction

endpackage

// ===== sv/tcpt_ctrl.sv =====
// tcpt_ctrl: controller state machine; counts vertices and sequences
// five determinants through the datapath. Depends on tcpt_pkg.
`timescale 1ns / 1ps

module tcpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tcpt_pkg::dp_cmd_t cmd
);
  import tcpt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RUN, S_SIGN, S_FINISH} state_t;

  state_t               state_r;
  logic [SLOT_BITS-1:0] count_r;
  logic [DET_BITS-1:0]  det_r;
  logic [STEP_BITS-1:0] step_r;
  logic                 out_valid_r;
  logic                 accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.wr_en    = accept;
    cmd.slot     = count_r;
    cmd.load     = (state_r == S_LOAD);
    cmd.step_vld = (state_r == S_RUN);
    cmd.step     = step_r;
    cmd.sign_cap = (state_r == S_SIGN);
    cmd.finish   = (state_r == S_FINISH);
    cmd.det_idx  = det_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      det_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r <= count_r + 1'b1;
            if (count_r == SLOT_LAST) begin
              det_r   <= '0;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          step_r  <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) state_r <= S_SIGN;
        end
        S_SIGN: begin
          if (det_r == DET_POS) begin
            state_r <= S_FINISH;
          end else begin
            det_r   <= det_r + 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/tcpt_datapath.sv =====
// tcpt_datapath: vertex registers, edge vectors, shared multiplier and
// exact determinant accumulator, parity and result. Depends on tcpt_pkg.
`timescale 1ns / 1ps

module tcpt_datapath #(
  parameter int VALUE_BITS  = 24,
  parameter int OFFSET_BITS = 26
) (
  input  logic                          clk,
  input  tcpt_pkg::dp_cmd_t             cmd,
  input  logic signed [VALUE_BITS-1:0]  vec_a,
  input  logic signed [VALUE_BITS-1:0]  vec_b,
  input  logic signed [VALUE_BITS-1:0]  vec_c,
  input  logic        [OFFSET_BITS-1:0] vertex_offset,
  input  logic signed [VALUE_BITS-1:0]  pos_lat,
  input  logic signed [VALUE_BITS-1:0]  pos_long,
  input  logic signed [VALUE_BITS-1:0]  pos_level,
  output logic        [1:0]             poincare_index
);
  import tcpt_pkg::*;

  localparam int D  = VALUE_BITS + 1;
  localparam int LO = D + 1;
  localparam int MW = D + 2;
  localparam int PW = 2 * MW;
  localparam int T  = 2 * D + 1;
  localparam int DW = 3 * D + 3;

  logic signed [VALUE_BITS-1:0] vec_r [4][3];
  logic signed [VALUE_BITS-1:0] pos_r [4][3];
  logic        [OFFSET_BITS-1:0] off_r [4];

  logic signed [VALUE_BITS-1:0] pa [3];
  logic signed [VALUE_BITS-1:0] pb [3];
  logic signed [VALUE_BITS-1:0] pc [3];
  logic signed [VALUE_BITS-1:0] pd [3];

  logic signed [D-1:0]  u_r [3];
  logic signed [D-1:0]  v_r [3];
  logic signed [D-1:0]  w_r [3];
  logic signed [T-1:0]  t_r;
  logic signed [DW-1:0] det_r;
  logic signed [PW-1:0] prod_r;
  logic [NUM_DETS-1:0]  sign_r;
  logic [1:0]           result_r;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [DW-1:0] prod_ext;
  step_ctl_t            sc;
  logic                 flip;
  logic [NUM_DETS-1:0]  o;

  assign poincare_index = result_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      vec_r[cmd.slot][0] <= vec_a;
      vec_r[cmd.slot][1] <= vec_b;
      vec_r[cmd.slot][2] <= vec_c;
      pos_r[cmd.slot][0] <= pos_lat;
      pos_r[cmd.slot][1] <= pos_long;
      pos_r[cmd.slot][2] <= pos_level;
      off_r[cmd.slot]    <= vertex_offset;
    end
  end

  // substitute the origin for one vertex, or take the positions
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.det_idx == DET_POS) begin
        pa[c] = pos_r[0][c];
        pb[c] = pos_r[1][c];
        pc[c] = pos_r[2][c];
        pd[c] = pos_r[3][c];
      end else begin
        pa[c] = (cmd.det_idx == DET_BITS'(0)) ? '0 : vec_r[0][c];
        pb[c] = (cmd.det_idx == DET_BITS'(1)) ? '0 : vec_r[1][c];
        pc[c] = (cmd.det_idx == DET_BITS'(2)) ? '0 : vec_r[2][c];
        pd[c] = (cmd.det_idx == DET_BITS'(3)) ? '0 : vec_r[3][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < 3; c++) begin
        u_r[c] <= {pb[c][VALUE_BITS-1], pb[c]} - {pa[c][VALUE_BITS-1], pa[c]};
        v_r[c] <= {pc[c][VALUE_BITS-1], pc[c]} - {pa[c][VALUE_BITS-1], pa[c]};
        w_r[c] <= {pd[c][VALUE_BITS-1], pd[c]} - {pa[c][VALUE_BITS-1], pa[c]};
      end
    end
  end

  assign sc = step_ctl(cmd.step);

  always_comb begin
    case (sc.a_sel)
      A_U0:    mul_a = MW'(u_r[0]);
      A_U1:    mul_a = MW'(u_r[1]);
      A_U2:    mul_a = MW'(u_r[2]);
      A_V0:    mul_a = MW'(v_r[0]);
      A_V1:    mul_a = MW'(v_r[1]);
      A_V2:    mul_a = MW'(v_r[2]);
      default: mul_a = '0;
    endcase
    case (sc.b_sel)
      B_W0:    mul_b = MW'(w_r[0]);
      B_W1:    mul_b = MW'(w_r[1]);
      B_W2:    mul_b = MW'(w_r[2]);
      B_TLO:   mul_b = $signed({1'b0, t_r[LO-1:0]});
      B_THI:   mul_b = $signed({{(MW-(T-LO)){t_r[T-1]}}, t_r[T-1:LO]});
      default: mul_b = '0;
    endcase
  end

  assign prod_ext = $signed({{(DW-PW){prod_r[PW-1]}}, prod_r});

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.step_vld) begin
      case (sc.acc)
        ACC_T_LOAD:     t_r   <= prod_r[T-1:0];
        ACC_T_SUB:      t_r   <= t_r - prod_r[T-1:0];
        ACC_DET_LOAD:   det_r <= prod_ext;
        ACC_DET_ADD:    det_r <= det_r + prod_ext;
        ACC_DET_ADD_HI: det_r <= det_r + (prod_ext <<< LO);
        default: ;
      endcase
    end
  end

  // negative 3x3 determinant means positive orientation
  always_ff @(posedge clk) begin
    if (cmd.sign_cap) sign_r[cmd.det_idx] <= det_r[DW-1];
  end

  always_comb begin
    flip = (off_r[0] < off_r[1]) ^ (off_r[0] < off_r[2]) ^ (off_r[0] < off_r[3])
         ^ (off_r[1] < off_r[2]) ^ (off_r[1] < off_r[3]) ^ (off_r[2] < off_r[3]);
    o = sign_r ^ {NUM_DETS{flip}};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if ((o[1] != o[0]) || (o[2] != o[0]) || (o[3] != o[0])) result_r <= IDX_NONE;
      else if (o[4] != o[0])                                  result_r <= IDX_NEG;
      else                                                    result_r <= IDX_POS;
    end
  end

endmodule

// ===== sv/tet_critical_point_test.sv =====
// tet_critical_point_test: top level; joins controller and datapath.
// Depends on tcpt_pkg, tcpt_ctrl and tcpt_datapath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | start high, busy lo | in_vec_a/b/c, in_vertex_offset, in_pos_*
//   result   | out_valid strobe    | out_poincare_index
//
// Vertices 0 to 2 are each stored without raising busy.
// The fourth vertex holds busy through five determinants (edge load,
// 16 steps on the shared multiplier, sign capture each), then a result
// state; out_valid pulses in the cycle busy drops. Synchronous reset
// clears the vertex count. The receiver cannot stall; a result lasts
// one cycle.
`timescale 1ns / 1ps

module tet_critical_point_test #(
  parameter int VALUE_BITS  = 24,
  parameter int OFFSET_BITS = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  in_vec_a,
  input  logic signed [VALUE_BITS-1:0]  in_vec_b,
  input  logic signed [VALUE_BITS-1:0]  in_vec_c,
  input  logic        [OFFSET_BITS-1:0] in_vertex_offset,
  input  logic signed [VALUE_BITS-1:0]  in_pos_lat,
  input  logic signed [VALUE_BITS-1:0]  in_pos_long,
  input  logic signed [VALUE_BITS-1:0]  in_pos_level,
  output logic                          out_valid,
  output logic signed [1:0]             out_poincare_index
);
  import tcpt_pkg::*;

  dp_cmd_t    cmd;
  logic [1:0] index;

  tcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tcpt_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .vec_a          (in_vec_a),
    .vec_b          (in_vec_b),
    .vec_c          (in_vec_c),
    .vertex_offset  (in_vertex_offset),
    .pos_lat        (in_pos_lat),
    .pos_long       (in_pos_long),
    .pos_level      (in_pos_level),
    .poincare_index (index)
  );

  assign out_poincare_index = $signed(index);

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without computation");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_index_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (index == IDX_NONE || index == IDX_POS || index == IDX_NEG))
    else $error("bad index code");

endmodule

// ===== dv/tet_critical_point_test_tb.sv =====
// Self-checking testbench for tet_critical_point_test: loads tetrahedra vertex by
// vertex and checks each Poincare index against an exact-determinant predictor.
// Depends on tcpt_pkg and the tet_critical_point_test RTL.
`timescale 1ns / 1ps

module tet_critical_point_test_tb;
  import tcpt_pkg::*;

  typedef struct {
    logic signed [23:0] vec_a, vec_b, vec_c;
    logic [25:0]        vertex_offset;
    logic signed [23:0] pos_lat, pos_long, pos_level;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_vec_a = '0, in_vec_b = '0, in_vec_c = '0;
  logic [25:0] in_vertex_offset = '0;
  logic signed [23:0] in_pos_lat = '0, in_pos_long = '0, in_pos_level = '0;
  logic out_valid;
  logic signed [1:0] out_poincare_index;

  vertex_t pending_vertices[$];
  logic [1:0] expected_index[$];
  vertex_t tet_buf[4];
  int loaded = 0;
  int errors = 0;
  int sent = 0;
  int gap = 0;
  bit in_xfer = 1'b0;
  bit hold_for_drain = 1'b0;
  int drain_at = 300;

  always #4 clk = ~clk;

  tet_critical_point_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vec_a(in_vec_a), .in_vec_b(in_vec_b), .in_vec_c(in_vec_c),
    .in_vertex_offset(in_vertex_offset), .in_pos_lat(in_pos_lat),
    .in_pos_long(in_pos_long), .in_pos_level(in_pos_level),
    .out_valid(out_valid), .out_poincare_index(out_poincare_index)
  );

  // det4 with last row of ones > 0 iff det3 of edges from a < 0
  function automatic bit det_positive(input logic signed [23:0] a[3],
      input logic signed [23:0] b[3], input logic signed [23:0] c[3],
      input logic signed [23:0] d[3]);
    logic signed [127:0] u[3], v[3], w[3], det;
    for (int k = 0; k < 3; k++) begin
      u[k] = 128'(b[k]) - 128'(a[k]);
      v[k] = 128'(c[k]) - 128'(a[k]);
      w[k] = 128'(d[k]) - 128'(a[k]);
    end
    det = u[0] * (v[1] * w[2] - v[2] * w[1])
        + u[1] * (v[2] * w[0] - v[0] * w[2])
        + u[2] * (v[0] * w[1] - v[1] * w[0]);
    return det < 0;
  endfunction

  function automatic int orientation(input logic signed [23:0] a[3],
      input logic signed [23:0] b[3], input logic signed [23:0] c[3],
      input logic signed [23:0] d[3], input bit flip);
    int s;
    s = det_positive(a, b, c, d) ? 1 : -1;
    return flip ? -s : s;
  endfunction

  function automatic logic [1:0] poincare_of(input vertex_t t[4]);
    logic signed [23:0] vv[4][3], pp[4][3], z[3];
    int asc, s;
    bit flip;
    asc = 0;
    z = '{24'sd0, 24'sd0, 24'sd0};
    for (int i = 0; i < 4; i++) begin
      vv[i] = '{t[i].vec_a, t[i].vec_b, t[i].vec_c};
      pp[i] = '{t[i].pos_lat, t[i].pos_long, t[i].pos_level};
      for (int j = i + 1; j < 4; j++)
        if (t[i].vertex_offset < t[j].vertex_offset) asc++;
    end
    flip = asc[0];
    s = orientation(z, vv[1], vv[2], vv[3], flip);
    if (orientation(vv[0], z, vv[2], vv[3], flip) != s ||
        orientation(vv[0], vv[1], z, vv[3], flip) != s ||
        orientation(vv[0], vv[1], vv[2], z, flip) != s)
      return IDX_NONE;
    if (orientation(pp[0], pp[1], pp[2], pp[3], flip) != s) return IDX_NEG;
    return IDX_POS;
  endfunction

  function automatic logic signed [23:0] rand_value(input int mode);
    case (mode)
      0: return 24'(32'($urandom));
      1: return 24'($signed($urandom_range(0, 2048)) - 1024);
      2: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  function automatic vertex_t rand_vertex(input int mode);
    vertex_t v;
    v.vec_a = rand_value(mode);
    v.vec_b = rand_value(mode);
    v.vec_c = rand_value(mode);
    v.vertex_offset = ($urandom_range(0, 3) == 0) ? 26'($urandom_range(0, 3))
                                                  : 26'($urandom);
    v.pos_lat = rand_value(mode);
    v.pos_long = rand_value(mode);
    v.pos_level = rand_value(mode);
    return v;
  endfunction

  // append one vertex to the pending transfers
  function automatic void enqueue_vertex(input vertex_t v);
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  // Tetrahedron around the origin with +/- s vectors: yields nonzero indices.
  function automatic void push_enclosing(input int scale, input bit mirror);
    vertex_t v;
    int sx[4][3];
    sx = '{'{1, 1, 1}, '{1, -1, -1}, '{-1, 1, -1}, '{-1, -1, 1}};
    for (int i = 0; i < 4; i++) begin
      v = rand_vertex($urandom_range(0, 3));
      v.vec_a = 24'(sx[i][0] * scale);
      v.vec_b = 24'(sx[i][1] * scale);
      v.vec_c = 24'((mirror ? -sx[i][2] : sx[i][2]) * scale);
      enqueue_vertex(v);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    vertex_t v;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_xfer) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (sent == drain_at && expected_index.size() != 0) begin
      start <= 1'b0;
    end else if (pending_vertices.size() != 0) begin
      v = pending_vertices.pop_front();
      in_vec_a <= v.vec_a;
      in_vec_b <= v.vec_b;
      in_vec_c <= v.vec_c;
      in_vertex_offset <= v.vertex_offset;
      in_pos_lat <= v.pos_lat;
      in_pos_long <= v.pos_long;
      in_pos_level <= v.pos_level;
      start <= 1'b1;
      sent <= sent + 1;
      gap <= ($urandom_range(0, 3) != 0) ? 0 :
             ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on each vertex transfer, check each result strobe
  always @(posedge clk) begin
    vertex_t v;
    in_xfer = rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        v.vec_a = in_vec_a; v.vec_b = in_vec_b; v.vec_c = in_vec_c;
        v.vertex_offset = in_vertex_offset;
        v.pos_lat = in_pos_lat; v.pos_long = in_pos_long; v.pos_level = in_pos_level;
        tet_buf[loaded] = v;
        if (loaded == 3) expected_index.insert(expected_index.size(), poincare_of(tet_buf));
        loaded = (loaded + 1) % 4;
      end
      if (out_valid) begin
        if (expected_index.size() == 0)
          report_mismatch("result with none expected");
        else if (out_poincare_index !== expected_index[0])
          report_mismatch($sformatf("poincare_index got %0d exp %0d",
                          out_poincare_index, $signed(expected_index[0])));
        if (expected_index.size() != 0) void'(expected_index.pop_front());
      end
    end
  end

  initial begin
    vertex_t v;
    // directed: extremes, degenerate, enclosing of both handedness
    for (int i = 0; i < 4; i++) begin
      v = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 26'h3ffffff,
            24'sh800000, 24'sh7fffff, 24'sh800000};
      if (i[0]) v = '{24'sh800000, 24'sh7fffff, 24'sh800000, 26'h0,
                      24'sh7fffff, 24'sh800000, 24'sh7fffff};
      enqueue_vertex(v);
    end
    for (int i = 0; i < 4; i++) begin
      v = '{default: '0};
      enqueue_vertex(v);
    end
    push_enclosing(256, 1'b0);
    push_enclosing(256, 1'b1);
    push_enclosing(8388607, 1'b0);
    push_enclosing(1, 1'b1);
    // random: about half enclosing tetrahedra, rest noise
    for (int t = 0; t < 125; t++) begin
      if ($urandom_range(0, 1)) push_enclosing($urandom_range(1, 8388607), $urandom_range(0, 1));
      else for (int i = 0; i < 4; i++) enqueue_vertex(rand_vertex($urandom_range(0, 3)));
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_vertices.size() == 0 && !start);
    wait (expected_index.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
